// ----- rtl/hsfc_pkg.sv -----
// Shared types and constants for the half/single float converter.
// No dependencies; every other file of the block refers to it by scoped names.
package hsfc_pkg;

  // The four lanes are fixed by the channel payload, so this is a constant.
  localparam int LANE_COUNT = 4;
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 3;

  typedef enum logic {
    OP_WIDEN  = 1'b0,   // half to single
    OP_NARROW = 1'b1    // single to half
  } opcode_t;

  typedef enum logic {
    RND_NEAREST_EVEN = 1'b0,
    RND_TRUNCATE     = 1'b1
  } round_mode_t;

  typedef logic [WORD_W-1:0]          word_t;
  typedef word_t [LANE_COUNT-1:0]     lanes_t;

  // Per-item control that every lane needs.
  typedef struct packed {
    opcode_t opcode;
    logic    nearest;
  } lane_ctl_t;

  // Contents of the register between the lanes and the merging stage.
  typedef struct packed {
    opcode_t              opcode;
    logic [COUNT_W-1:0]   lanes_valid;
    lanes_t               res;
  } stage_t;

  // Field constants of the two formats.
  localparam logic [4:0]  HALF_EXP_MAX    = 5'h1F;
  localparam logic [7:0]  SGL_EXP_MAX     = 8'hFF;
  localparam logic [7:0]  HALF_SGL_BIAS   = 8'd112;  // 127 - 15
  localparam logic [7:0]  SUB_EXP_BASE    = 8'd103;  // 127 - 14 - 10
  localparam logic [7:0]  NARROW_OVF_EXP  = 8'd143;  // half exponent 31
  localparam logic [7:0]  NARROW_NORM_EXP = 8'd113;  // half exponent 1
  localparam logic [7:0]  NARROW_SUB_EXP  = 8'd102;  // smallest that keeps a bit
  localparam logic [7:0]  SUB_SHIFT_BASE  = 8'd126;  // 13 + (1 - ne) + 112
  localparam logic [14:0] HALF_INF        = 15'h7C00;
  localparam logic [9:0]  HALF_QUIET      = 10'h200;

endpackage

// ----- rtl/hsfc_if.sv -----
// Channel interfaces of the half/single float converter: input items,
// result items and the rounding-mode write port. Depends on hsfc_pkg.

interface hsfc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [hsfc_pkg::COUNT_W-1:0]  lanes_valid;
  hsfc_pkg::word_t               in_lane_0;
  hsfc_pkg::word_t               in_lane_1;
  hsfc_pkg::word_t               in_lane_2;
  hsfc_pkg::word_t               in_lane_3;

  modport source (output valid, opcode, lanes_valid, in_lane_0, in_lane_1,
                  in_lane_2, in_lane_3, input ready);
  modport sink   (input valid, opcode, lanes_valid, in_lane_0, in_lane_1,
                  in_lane_2, in_lane_3, output ready);
endinterface

interface hsfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [hsfc_pkg::COUNT_W-1:0]  out_lanes_valid;
  hsfc_pkg::word_t               out_lane_0;
  hsfc_pkg::word_t               out_lane_1;
  hsfc_pkg::word_t               out_lane_2;
  hsfc_pkg::word_t               out_lane_3;

  modport source (output valid, out_lanes_valid, out_lane_0, out_lane_1,
                  out_lane_2, out_lane_3, input ready);
  modport sink   (input valid, out_lanes_valid, out_lane_0, out_lane_1,
                  out_lane_2, out_lane_3, output ready);
endinterface

interface hsfc_cfg_if;
  logic valid;
  logic ready;
  logic round_mode;

  modport source (output valid, round_mode, input ready);
  modport sink   (input valid, round_mode, output ready);
endinterface

// ----- rtl/half_single_float_converter_core.sv -----
// Top level of the half/single float converter: four conversion lanes,
// a lane result register and the merging output stage.
// Depends on hsfc_pkg, hsfc_if, hsfc_lane and hsfc_merge.
//
// Usage:
//   src carries input items (opcode, lanes_valid, in_lane_0..3) with a
//   valid/ready transfer. Opcode OP_WIDEN turns the low 16 bits of each
//   lane from half into single; OP_NARROW turns each 32-bit single into a
//   half placed in the low 16 bits. Lanes at or beyond lanes_valid give 0.
//   dst carries result items, one per input item, in order.
//   cfg writes round_mode (0 nearest even, 1 truncate); it is always ready
//   and should be written only while no item is in flight.
//
// Timing:
//   A result passes from its input transfer through the four parallel lanes
//   into the lane result register, then through the merging stage into the
//   output register. One item is taken every cycle while dst does not stall.
//
// Reset (rst, synchronous) empties both stages and sets round_mode to
// nearest even. When dst stalls, the output register holds its item and the
// lane result register can still take one more item before src.ready drops.
module half_single_float_converter_core (
  input  logic       clk,
  input  logic       rst,
  hsfc_in_if.sink    src,
  hsfc_out_if.source dst,
  hsfc_cfg_if.sink   cfg
);

  hsfc_pkg::round_mode_t round_mode;
  hsfc_pkg::lane_ctl_t   ctl;
  hsfc_pkg::lanes_t      lane_src;
  hsfc_pkg::lanes_t      lane_res;
  hsfc_pkg::stage_t      stage;
  logic                  stage_valid;
  logic                  merge_ready;
  logic                  accept;

  // The write port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_mode <= hsfc_pkg::RND_NEAREST_EVEN;
    end else if (cfg.valid) begin
      round_mode <= hsfc_pkg::round_mode_t'(cfg.round_mode);
    end
  end

  assign ctl.opcode  = hsfc_pkg::opcode_t'(src.opcode);
  assign ctl.nearest = (round_mode == hsfc_pkg::RND_NEAREST_EVEN);

  assign lane_src[0] = src.in_lane_0;
  assign lane_src[1] = src.in_lane_1;
  assign lane_src[2] = src.in_lane_2;
  assign lane_src[3] = src.in_lane_3;

  // The lanes are independent copies of the same converter.
  for (genvar g = 0; g < hsfc_pkg::LANE_COUNT; g++) begin : g_lane
    hsfc_lane u_lane (
      .ctl (ctl),
      .src (lane_src[g]),
      .res (lane_res[g])
    );
  end

  // The lane result register advances whenever the merging stage can take
  // its content, so a full pipeline still moves one item per cycle while dst is ready.
  assign src.ready = !stage_valid || merge_ready;
  assign accept    = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src.ready) begin
      stage_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.opcode      <= ctl.opcode;
      stage.lanes_valid <= src.lanes_valid;
      stage.res         <= lane_res;
    end
  end

  hsfc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid),
    .in_ready (merge_ready),
    .in_data  (stage),
    .dst      (dst)
  );

  // Both stages full and the receiver stalled: no new item may enter.
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stage_valid && dst.valid && !dst.ready |-> !src.ready)
    else $error("input taken while pipeline is full");

  // An accepted item always lands in the lane result register.
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> stage_valid)
    else $error("accepted item lost");

  // Reset leaves no result on the output channel.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !dst.valid && !stage_valid)
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/hsfc_lane.sv -----
// One conversion lane: half to single widening or single to half narrowing.
// Pure combinational logic; depends on hsfc_pkg.
module hsfc_lane (
  input  hsfc_pkg::lane_ctl_t ctl,
  input  hsfc_pkg::word_t     src,
  output hsfc_pkg::word_t     res
);

  hsfc_pkg::word_t widen;
  logic [15:0]     narrow;

  // Widening path.
  always_comb begin
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  top;
    logic [3:0]  sh;
    logic [10:0] norm;
    logic [7:0]  expn;
    s    = src[15];
    e    = src[14:10];
    m    = src[9:0];
    top  = '0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        top = 4'(i);
      end
    end
    sh   = 4'd10 - top;
    norm = {1'b0, m} << sh;
    expn = hsfc_pkg::SUB_EXP_BASE + {4'b0, top};
    if (e == 5'd0) begin
      if (m == 10'd0) begin
        widen = {s, 31'd0};
      end else begin
        widen = {s, expn, norm[9:0], 13'd0};
      end
    end else if (e == hsfc_pkg::HALF_EXP_MAX) begin
      // The payload moves up by 13; its top bit lands under the forced quiet bit.
      widen = {s, hsfc_pkg::SGL_EXP_MAX, (m != 10'd0), m[8:0], 13'd0};
    end else begin
      widen = {s, 8'({3'b0, e} + hsfc_pkg::HALF_SGL_BIAS), m, 13'd0};
    end
  end

  // Narrowing path with guard and sticky rounding.
  always_comb begin
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  ne;
    logic        inc_n;
    logic [15:0] rn;
    logic [4:0]  shamt;
    logic [47:0] ext;
    logic        inc_s;
    s     = src[31];
    e     = src[30:23];
    m     = src[22:0];
    ne    = 5'(e - hsfc_pkg::HALF_SGL_BIAS);
    inc_n = ctl.nearest && m[12] && ((|m[11:0]) || m[13]);
    rn    = {1'b0, ne, m[22:13]} + 16'(inc_n);
    shamt = 5'(hsfc_pkg::SUB_SHIFT_BASE - e);
    ext   = {1'b1, m, 24'd0} >> shamt;
    inc_s = ctl.nearest && ext[23] && ((|ext[22:0]) || ext[24]);
    if (e == 8'd0) begin
      narrow = {s, 15'd0};
    end else if (e == hsfc_pkg::SGL_EXP_MAX) begin
      if (m == 23'd0) begin
        narrow = {s, hsfc_pkg::HALF_INF};
      end else begin
        narrow = {s, hsfc_pkg::HALF_EXP_MAX, hsfc_pkg::HALF_QUIET | m[22:13]};
      end
    end else if (e >= hsfc_pkg::NARROW_OVF_EXP) begin
      narrow = {s, hsfc_pkg::HALF_INF};
    end else if (e >= hsfc_pkg::NARROW_NORM_EXP) begin
      if (rn[14:0] >= hsfc_pkg::HALF_INF) begin
        narrow = {s, hsfc_pkg::HALF_INF};
      end else begin
        narrow = {s, rn[14:0]};
      end
    end else if (e >= hsfc_pkg::NARROW_SUB_EXP) begin
      narrow = {s, 15'(ext[38:24] + 15'(inc_s))};
    end else begin
      narrow = {s, 15'd0};
    end
  end

  assign res = (ctl.opcode == hsfc_pkg::OP_NARROW) ? {16'd0, narrow} : widen;

endmodule

// ----- rtl/hsfc_merge.sv -----
// Merging stage: zeroes lanes beyond the valid count and holds the result
// item in the output register. Depends on hsfc_pkg and hsfc_if.
module hsfc_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsfc_pkg::stage_t   in_data,
  hsfc_out_if.source         dst
);

  hsfc_pkg::lanes_t masked;
  hsfc_pkg::lanes_t lanes;
  logic [hsfc_pkg::COUNT_W-1:0] count;
  logic             out_valid;
  logic             is_narrow;

  always_comb begin
    for (int i = 0; i < hsfc_pkg::LANE_COUNT; i++) begin
      masked[i] = (hsfc_pkg::COUNT_W'(i) < in_data.lanes_valid) ? in_data.res[i] : '0;
    end
  end

  assign in_ready = !out_valid || dst.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lanes     <= masked;
      count     <= in_data.lanes_valid;
      is_narrow <= (in_data.opcode == hsfc_pkg::OP_NARROW);
    end
  end

  assign dst.valid           = out_valid;
  assign dst.out_lanes_valid = count;
  assign dst.out_lane_0      = lanes[0];
  assign dst.out_lane_1      = lanes[1];
  assign dst.out_lane_2      = lanes[2];
  assign dst.out_lane_3      = lanes[3];

  // A narrowed result never carries bits above the half word.
  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_narrow |-> (lanes[0][31:16] == 16'd0) && (lanes[1][31:16] == 16'd0)
      && (lanes[2][31:16] == 16'd0) && (lanes[3][31:16] == 16'd0))
    else $error("narrowed lane has upper bits set");

  // With no valid lanes every lane reads zero.
  a_empty_item_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (count == '0) |-> (lanes == '0))
    else $error("invalid lanes not zeroed");

endmodule

// ----- sim/half_single_float_converter_core_tb.sv -----
// Self-checking testbench for half_single_float_converter_core: widening and
// narrowing items with random flow control on both channels, checked against
// a local predictor. Depends on hsfc_pkg, hsfc_if and the converter RTL.
`timescale 1ns / 1ps

module half_single_float_converter_core_tb;

  // One input item as it crosses src, and one result item as it crosses dst.
  typedef struct packed {
    hsfc_pkg::opcode_t            opcode;
    logic [hsfc_pkg::COUNT_W-1:0] lanes_valid;
    hsfc_pkg::lanes_t             lane;
  } conv_item_t;

  typedef struct packed {
    logic [hsfc_pkg::COUNT_W-1:0] lanes_valid;
    hsfc_pkg::lanes_t             lane;
  } conv_result_t;

  logic clk;
  logic rst;

  hsfc_in_if  src_if ();
  hsfc_out_if dst_if ();
  hsfc_cfg_if cfg_if ();

  half_single_float_converter_core i_dut (
    .clk (clk),
    .rst (rst),
    .src (src_if),
    .dst (dst_if),
    .cfg (cfg_if)
  );

  // Items waiting to be driven, and conversions predicted for accepted items.
  conv_item_t   conv_items_q[$];
  conv_result_t expected_results_q[$];

  // The testbench's own copy of the rounding-mode register. It follows the
  // cfg transfers, which only happen while no item is in flight.
  hsfc_pkg::round_mode_t round_mode_copy;
  int unsigned  mismatch_count;
  // When set, neither side inserts gaps, so the pipeline runs at full rate.
  logic         steady_flow;
  int unsigned  src_gap;
  int unsigned  dst_stall;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Shift right by sh (1..31); with nearest set, round to nearest, ties to even.
  function automatic logic [31:0] shift_and_round(logic [31:0] v, int unsigned sh,
                                                  logic nearest);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] halfway;
    q       = v >> sh;
    rem     = v & ((32'd1 << sh) - 32'd1);
    halfway = 32'd1 << (sh - 1);
    if (nearest && (rem > halfway || (rem == halfway && q[0]))) begin
      q = q + 32'd1;
    end
    return q;
  endfunction

  // Half to single. Subnormals are normalized by shifting the significand
  // until its hidden bit appears; NaNs come out quiet with the payload on top.
  function automatic hsfc_pkg::word_t widen_half(logic [15:0] h);
    logic [4:0]  e;
    logic [10:0] m;
    int unsigned sh;
    e  = h[14:10];
    m  = {1'b0, h[9:0]};
    sh = 0;
    if (e == 5'h00) begin
      if (m == 11'h0) begin
        return {h[15], 31'h0};
      end
      while (!m[10]) begin
        m  = m << 1;
        sh = sh + 1;
      end
      return {h[15], 8'(113 - sh), m[9:0], 13'h0};
    end
    if (e == 5'h1F) begin
      if (m == 11'h0) begin
        return {h[15], 8'hFF, 23'h0};
      end
      return {h[15], 8'hFF, 1'b1, m[8:0], 13'h0};
    end
    return {h[15], {3'b000, e} + 8'd112, m[9:0], 13'h0};
  endfunction

  // Single to half. Single subnormals flush to signed zero, overflow and any
  // rounding carry into the top exponent saturate at infinity, and values
  // below the half normal range are shifted into the subnormal range.
  function automatic logic [15:0] narrow_single(hsfc_pkg::word_t b, logic nearest);
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] m;
    int          ne;
    int unsigned sh;
    logic [31:0] r;
    sgn = b[31];
    e   = b[30:23];
    m   = b[22:0];
    if (e == 8'h00) begin
      return {sgn, 15'h0};
    end
    if (e == 8'hFF) begin
      if (m == 23'h0) begin
        return {sgn, 15'h7C00};
      end
      return {sgn, 5'h1F, 10'h200 | m[22:13]};
    end
    ne = int'(e) - 112;
    if (ne >= 31) begin
      return {sgn, 15'h7C00};
    end
    if (ne >= 1) begin
      r = shift_and_round((32'(ne) << 23) | {9'h0, m}, 13, nearest);
      if (r >= 32'h7C00) begin
        r = 32'h7C00;
      end
      return {sgn, r[14:0]};
    end
    sh = 1 - ne;
    if (sh >= 12) begin
      return {sgn, 15'h0};
    end
    r = shift_and_round({9'h0, m} | 32'h0080_0000, 13 + sh, nearest);
    return {sgn, r[14:0]};
  endfunction

  // A count above the lane number makes every lane valid; the raw count is
  // still echoed. Lanes at or beyond the count come out as zero.
  function automatic conv_result_t predict_conversion(conv_item_t it,
                                                      hsfc_pkg::round_mode_t mode);
    conv_result_t res;
    int unsigned  active;
    active          = (it.lanes_valid > hsfc_pkg::LANE_COUNT) ? hsfc_pkg::LANE_COUNT
                                                              : it.lanes_valid;
    res.lanes_valid = it.lanes_valid;
    for (int i = 0; i < hsfc_pkg::LANE_COUNT; i++) begin
      if (i >= active) begin
        res.lane[i] = '0;
      end else if (it.opcode == hsfc_pkg::OP_WIDEN) begin
        res.lane[i] = widen_half(it.lane[i][15:0]);
      end else begin
        res.lane[i] = {16'h0,
                       narrow_single(it.lane[i], mode == hsfc_pkg::RND_NEAREST_EVEN)};
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (steady_flow || r < 11) begin
      return 0;
    end
    if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  // Half sources: the exponent is steered toward zero and all-ones so that
  // subnormals, infinities and NaNs come often; the upper bits are junk.
  function automatic hsfc_pkg::word_t random_half_source();
    logic [15:0] junk;
    logic [4:0]  e;
    logic [9:0]  m;
    int unsigned sel;
    junk = 16'($urandom);
    m    = 10'($urandom);
    sel  = $urandom_range(0, 9);
    if (sel < 3) begin
      return $urandom;
    end
    if (sel < 5) begin
      e = 5'h00;
    end else if (sel < 7) begin
      e = 5'h1F;
    end else begin
      e = 5'($urandom);
    end
    // A single set bit gives every normalization depth of a subnormal.
    if (sel == 3) begin
      m = 10'd1 << $urandom_range(0, 9);
    end
    return {junk, 1'($urandom), e, m};
  endfunction

  // Single sources: exponents cluster around the half range, where rounding,
  // the subnormal boundary and overflow all sit. Some get tie patterns in
  // the dropped bits, some an all-ones kept mantissa to force carries.
  function automatic hsfc_pkg::word_t random_single_source();
    logic [7:0]  e;
    logic [22:0] m;
    int unsigned sel;
    m   = 23'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      return $urandom;
    end
    if (sel == 3) begin
      e = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      e = 8'($urandom_range(98, 146));
    end
    if (sel >= 7) begin
      case ($urandom_range(0, 3))
        0: m[12:0] = 13'h1000;
        1: m[12:0] = 13'h0FFF;
        2: m[12:0] = 13'h1001;
        default: m[12:0] = 13'h0000;
      endcase
      if (sel == 9) begin
        m[22:13] = '1;
      end
    end
    return {1'($urandom), e, m};
  endfunction

  task automatic queue_item(hsfc_pkg::opcode_t op, logic [hsfc_pkg::COUNT_W-1:0] count,
                            hsfc_pkg::word_t a, hsfc_pkg::word_t b,
                            hsfc_pkg::word_t c, hsfc_pkg::word_t d);
    conv_item_t it;
    it.opcode      = op;
    it.lanes_valid = count;
    it.lane        = {d, c, b, a};
    conv_items_q.push_back(it);
  endtask

  task automatic queue_random_item();
    conv_item_t it;
    it.opcode      = $urandom_range(0, 1) ? hsfc_pkg::OP_NARROW : hsfc_pkg::OP_WIDEN;
    // Full items dominate; every count from zero to seven still shows up.
    it.lanes_valid = ($urandom_range(0, 9) < 6) ? 3'd4 : 3'($urandom_range(0, 7));
    for (int i = 0; i < hsfc_pkg::LANE_COUNT; i++) begin
      it.lane[i] = (it.opcode == hsfc_pkg::OP_WIDEN) ? random_half_source()
                                                     : random_single_source();
    end
    conv_items_q.push_back(it);
  endtask

  // Directed set: format extremes, every special case of both directions,
  // and lane counts from zero to above the lane number.
  task automatic queue_directed_items();
    // Signed zeros, smallest and largest subnormal.
    queue_item(hsfc_pkg::OP_WIDEN, 3'd4, 32'h0000_0000, 32'h0000_8000, 32'h0000_0001,
               32'h0000_83FF);
    // Smallest and largest normal, both infinities.
    queue_item(hsfc_pkg::OP_WIDEN, 3'd4, 32'h0000_0400, 32'h0000_7BFF, 32'h0000_7C00,
               32'h0000_FC00);
    // NaNs with small, full and quiet-only payloads; junk in the upper half.
    queue_item(hsfc_pkg::OP_WIDEN, 3'd4, 32'h0000_7C01, 32'hFFFF_FFFF, 32'h0000_FE00,
               32'hABCD_3C00);
    // A count above the lane number.
    queue_item(hsfc_pkg::OP_WIDEN, 3'd7, 32'hFFFF_0001, 32'h0000_3555, 32'h0000_C000,
               32'h0000_0200);
    // No valid lanes at all.
    queue_item(hsfc_pkg::OP_WIDEN, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    queue_item(hsfc_pkg::OP_WIDEN, 3'd3, 32'h0000_3C00, 32'h0000_0155, 32'h0000_7E00,
               32'hFFFF_FFFF);
    // Signed zeros and single subnormals, which flush to signed zero.
    queue_item(hsfc_pkg::OP_NARROW, 3'd4, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
               32'h807F_FFFF);
    // Infinities and NaNs, one with its payload below the kept bits.
    queue_item(hsfc_pkg::OP_NARROW, 3'd4, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001,
               32'hFFFF_FFFF);
    // Largest half, a tie that rounds into infinity, plain overflow, and a
    // value just under the tie.
    queue_item(hsfc_pkg::OP_NARROW, 3'd4, 32'h477F_E000, 32'h477F_F000, 32'h4780_0000,
               32'hC77F_EFFF);
    // Smallest normal, smallest subnormal, a tie down to zero, just above it.
    queue_item(hsfc_pkg::OP_NARROW, 3'd4, 32'h3880_0000, 32'h3380_0000, 32'h3300_0000,
               32'h3300_0001);
    // Subnormal carry into the smallest normal, ties to even both ways, and
    // a value too small to keep any bit.
    queue_item(hsfc_pkg::OP_NARROW, 3'd4, 32'h387F_F000, 32'h3F80_1000, 32'h3F80_3000,
               32'h3280_0000);
    queue_item(hsfc_pkg::OP_NARROW, 3'd2, 32'h3C00_0000, 32'hBC00_0000, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    queue_item(hsfc_pkg::OP_NARROW, 3'd6, 32'h4049_0FDB, 32'hC2F6_E979, 32'h3555_5555,
               32'hB8FF_FFFF);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatch_count = mismatch_count + 1;
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. A new item (or a gap) is put on src only when the bus is
  // empty or its item was just taken, so valid never drops mid-transfer.
  // The prediction is made from the bus as the block saw it at the transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : input_driver
    conv_item_t taken;
    conv_item_t next_item;
    if (rst) begin
      src_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (src_if.valid && src_if.ready) begin
        taken.opcode      = hsfc_pkg::opcode_t'(src_if.opcode);
        taken.lanes_valid = src_if.lanes_valid;
        taken.lane        = {src_if.in_lane_3, src_if.in_lane_2,
                             src_if.in_lane_1, src_if.in_lane_0};
        expected_results_q.push_back(predict_conversion(taken, round_mode_copy));
      end
      if (!src_if.valid || src_if.ready) begin
        if (src_gap != 0) begin
          src_if.valid <= 1'b0;
          src_gap = src_gap - 1;
        end else if (conv_items_q.size() != 0) begin
          next_item = conv_items_q.pop_front();
          src_if.opcode      <= next_item.opcode;
          src_if.lanes_valid <= next_item.lanes_valid;
          src_if.in_lane_0   <= next_item.lane[0];
          src_if.in_lane_1   <= next_item.lane[1];
          src_if.in_lane_2   <= next_item.lane[2];
          src_if.in_lane_3   <= next_item.lane[3];
          src_if.valid       <= 1'b1;
          src_gap = pick_gap();
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure: ready drops for random stretches, so stalls
  // land on both pipeline stages and exercise the one-item slack.
  always @(posedge clk) begin : result_stall
    if (rst) begin
      dst_if.ready <= 1'b0;
      dst_stall = 0;
    end else if (dst_stall != 0) begin
      dst_if.ready <= 1'b0;
      dst_stall = dst_stall - 1;
    end else begin
      dst_if.ready <= 1'b1;
      dst_stall = pick_gap();
    end
  end

  // Result monitor: every transfer on dst is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin : result_monitor
    conv_result_t     want;
    hsfc_pkg::lanes_t got;
    if (!rst && dst_if.valid && dst_if.ready) begin
      got = {dst_if.out_lane_3, dst_if.out_lane_2, dst_if.out_lane_1, dst_if.out_lane_0};
      if (expected_results_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: count %0d lanes %h",
                                  dst_if.out_lanes_valid, got));
      end else begin
        want = expected_results_q.pop_front();
        if (dst_if.out_lanes_valid !== want.lanes_valid) begin
          report_mismatch($sformatf("out_lanes_valid got %0d want %0d",
                                    dst_if.out_lanes_valid, want.lanes_valid));
        end
        for (int i = 0; i < hsfc_pkg::LANE_COUNT; i++) begin
          if (got[i] !== want.lane[i]) begin
            report_mismatch($sformatf("out_lane_%0d got %h want %h",
                                      i, got[i], want.lane[i]));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Wait until every queued item has been taken and every result has come.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (conv_items_q.size() != 0 || src_if.valid || expected_results_q.size() != 0);
  endtask

  // The block is idle here; the task still waits before the register changes,
  // to cover the two pipeline stages. The local copy follows at the transfer.
  task automatic write_round_mode(hsfc_pkg::round_mode_t mode);
    repeat (4) @(posedge clk);
    cfg_if.round_mode <= mode;
    cfg_if.valid      <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    cfg_if.valid    <= 1'b0;
    round_mode_copy = mode;
  endtask

  initial begin : stimulus
    hsfc_pkg::round_mode_t mode;
    rst             = 1'b1;
    src_if.valid    = 1'b0;
    src_if.opcode   = hsfc_pkg::OP_WIDEN;
    src_if.lanes_valid = '0;
    src_if.in_lane_0 = '0;
    src_if.in_lane_1 = '0;
    src_if.in_lane_2 = '0;
    src_if.in_lane_3 = '0;
    dst_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.round_mode = hsfc_pkg::RND_NEAREST_EVEN;
    round_mode_copy = hsfc_pkg::RND_NEAREST_EVEN;
    mismatch_count  = 0;
    steady_flow     = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // The directed set runs first with the reset rounding mode, then again
    // with truncation.
    queue_directed_items();
    wait_drained();
    write_round_mode(hsfc_pkg::RND_TRUNCATE);
    queue_directed_items();
    wait_drained();

    // Random phases alternate the rounding mode; one of them runs without
    // any gaps to keep the pipeline full for a long stretch.
    for (int phase = 0; phase < 4; phase++) begin
      mode = phase[0] ? hsfc_pkg::RND_TRUNCATE : hsfc_pkg::RND_NEAREST_EVEN;
      write_round_mode(mode);
      steady_flow = (phase == 2);
      for (int k = 0; k < 125; k++) begin
        queue_random_item();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("half_single_float_converter_core_tb: PASS");
    end else begin
      $display("half_single_float_converter_core_tb: FAIL");
    end
    $finish;
  end

  // A correct run ends well before this timeout even with every gap at its
  // longest; this only catches a hang.
  initial begin : watchdog
    #20_000_000;
    $display("half_single_float_converter_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hsfc_pkg.sv
rtl/hsfc_if.sv
rtl/hsfc_lane.sv
rtl/hsfc_merge.sv
rtl/half_single_float_converter_core.sv
sim/half_single_float_converter_core_tb.sv
